// ----- hdl/lpf_pkg.sv -----
package lpf_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] ST_LOADED  = 2'd0;
    localparam logic [1:0] ST_FOUND   = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_RDATA   = 2'd3;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7a;

    localparam logic [7:0] SHIFT_BASE_RST = 8'd97;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_RD   = 8'b0000_0010,
        S_SEED = 8'b0000_0100,
        S_MIR  = 8'b0000_1000,
        S_EXT  = 8'b0001_0000,
        S_CMP  = 8'b0010_0000,
        S_UPD  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

endpackage

// ----- hdl/lpf_ram.sv -----
module lpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/longest_palindrome_finder.sv -----
// load transfer: result registered in the cycle after acceptance, one character per cycle while the result slot is free
// read transfer: after acceptance, text ram read, decode into the result slot, then output register
// search after the last character: each separated position goes through seed, mirror when inside
// the reach, extend and compare steps, and update, all on one sequencer
// input is not ready while a read or search is in progress or the result slot is held
// synchronous active-low reset clears length, control and shift base; rams are not cleared
module longest_palindrome_finder #(
    parameter int MAX_LEN = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_char_in,
    input  logic        i_is_last,
    input  logic [11:0] i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [11:0] o_first_pos,
    output logic [11:0] o_end_pos,
    output logic [7:0]  o_char_out
);

    localparam int LW  = $clog2(MAX_LEN);
    localparam int NW  = $clog2(MAX_LEN + 1);
    localparam int SEP = 2 * MAX_LEN + 2;
    localparam int PW  = $clog2(SEP);
    localparam int CW  = (NW > 12) ? NW : 12;

    lpf_pkg::t_state r_state, n_state;

    logic [7:0]    r_shift_base;
    logic [NW-1:0] r_len, n_len;
    logic          r_new, n_new;
    logic          r_hit, n_hit;
    logic [PW-1:0] r_i, n_i;
    logic [PW-1:0] r_r, n_r;
    logic [PW:0]   r_reach, n_reach;
    logic [PW-1:0] r_center, n_center;
    logic [PW-1:0] r_best, n_best;
    logic [PW-1:0] r_last, n_last;
    logic [PW-1:0] r_fpos, n_fpos;
    logic [PW-1:0] r_epos, n_epos;
    logic          r_found, n_found;
    logic [1:0]    r_res_status, n_res_status;
    logic [7:0]    r_res_char, n_res_char;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_status, n_status;
    logic [11:0]   r_first_pos, n_first_pos;
    logic [11:0]   r_end_pos, n_end_pos;
    logic [7:0]    r_char_out, n_char_out;

    logic          in_xfer;
    logic          slot_free;
    logic [NW-1:0] len_eff;
    logic          room;
    logic [NW-1:0] len_load;
    logic          txt_we;
    logic [LW-1:0] txt_raddr_a;
    logic [LW-1:0] txt_raddr_b;
    logic [7:0]    txt_rdata_a;
    logic [7:0]    txt_rdata_b;
    logic          rad_we;
    logic [PW-1:0] rad_raddr;
    logic [PW-1:0] rad_rdata;
    logic [PW-1:0] lo_pos;
    logic [PW-1:0] hi_pos;
    logic [PW:0]   ext_sum;
    logic [PW:0]   limit;
    logic          ext_ok;
    logic [7:0]    dec_char;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == lpf_pkg::S_IDLE) && slot_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign len_eff  = r_new ? '0 : r_len;
    assign room     = len_eff < NW'(MAX_LEN);
    assign len_load = room ? len_eff + NW'(1) : len_eff;
    assign txt_we   = in_xfer && (i_command == lpf_pkg::CMD_LOAD) && room;

    assign lo_pos  = r_i - r_r;
    assign hi_pos  = r_i + r_r;
    assign ext_sum = (PW+1)'(r_i) + (PW+1)'(r_r);
    assign ext_ok  = (r_r < r_i) && (ext_sum <= (PW+1)'(r_last));
    assign limit   = r_reach - (PW+1)'(r_i);

    assign txt_raddr_a = (r_state == lpf_pkg::S_IDLE) ? LW'(i_read_index)
                                                      : LW'((lo_pos - PW'(2)) >> 1);
    assign txt_raddr_b = LW'((hi_pos - PW'(2)) >> 1);
    assign rad_raddr   = PW'({r_center, 1'b0} - (PW+1)'(r_i));
    assign rad_we      = (r_state == lpf_pkg::S_UPD);

    // letter shift, wraps below the base from 'z'
    always_comb begin
        if (txt_rdata_a >= r_shift_base) begin
            dec_char = txt_rdata_a - r_shift_base + lpf_pkg::CHAR_A;
        end else begin
            dec_char = lpf_pkg::CHAR_Z - (r_shift_base - txt_rdata_a - 8'd1);
        end
    end

    // two copies so both ends of a candidate are read in the same cycle
    lpf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_a (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (LW'(len_eff)),
        .i_wdata (i_char_in),
        .i_raddr (txt_raddr_a),
        .o_rdata (txt_rdata_a)
    );

    lpf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_b (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (LW'(len_eff)),
        .i_wdata (i_char_in),
        .i_raddr (txt_raddr_b),
        .o_rdata (txt_rdata_b)
    );

    lpf_ram #(.WIDTH(PW), .DEPTH(SEP)) u_radius (
        .i_clk   (i_clk),
        .i_we    (rad_we),
        .i_waddr (r_i),
        .i_wdata (r_r),
        .i_raddr (rad_raddr),
        .o_rdata (rad_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_new        = r_new;
        n_hit        = r_hit;
        n_i          = r_i;
        n_r          = r_r;
        n_reach      = r_reach;
        n_center     = r_center;
        n_best       = r_best;
        n_last       = r_last;
        n_fpos       = r_fpos;
        n_epos       = r_epos;
        n_found      = r_found;
        n_res_status = r_res_status;
        n_res_char   = r_res_char;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_status     = r_status;
        n_first_pos  = r_first_pos;
        n_end_pos    = r_end_pos;
        n_char_out   = r_char_out;

        case (r_state)
            lpf_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (i_command == lpf_pkg::CMD_READ) begin
                        n_hit   = CW'(i_read_index) < CW'(r_len);
                        n_state = lpf_pkg::S_RD;
                    end else begin
                        n_len = len_load;
                        n_new = 1'b0;
                        if (i_is_last) begin
                            n_new      = 1'b1;
                            n_i        = PW'(1);
                            n_reach    = '0;
                            n_center   = '0;
                            n_best     = '0;
                            n_fpos     = '0;
                            n_epos     = '0;
                            n_found    = 1'b0;
                            n_res_char = '0;
                            n_last     = PW'({len_load, 1'b0}) + PW'(1);
                            n_state    = lpf_pkg::S_SEED;
                        end else begin
                            n_out_valid = 1'b1;
                            n_status    = lpf_pkg::ST_LOADED;
                            n_first_pos = '0;
                            n_end_pos   = '0;
                            n_char_out  = '0;
                        end
                    end
                end
            end
            lpf_pkg::S_RD: begin
                n_res_status = lpf_pkg::ST_RDATA;
                n_res_char   = r_hit ? dec_char : '0;
                n_fpos       = '0;
                n_epos       = '0;
                n_state      = lpf_pkg::S_OUT;
            end
            lpf_pkg::S_SEED: begin
                if (r_reach > (PW+1)'(r_i)) begin
                    n_state = lpf_pkg::S_MIR;
                end else begin
                    n_r     = PW'(1);
                    n_state = lpf_pkg::S_EXT;
                end
            end
            lpf_pkg::S_MIR: begin
                n_r     = ((PW+1)'(rad_rdata) < limit) ? rad_rdata : PW'(limit);
                n_state = lpf_pkg::S_EXT;
            end
            lpf_pkg::S_EXT: begin
                if (!ext_ok) begin
                    n_state = lpf_pkg::S_UPD;
                end else if (lo_pos[0]) begin
                    n_r = r_r + PW'(1);
                end else begin
                    n_state = lpf_pkg::S_CMP;
                end
            end
            lpf_pkg::S_CMP: begin
                if (txt_rdata_a == txt_rdata_b) begin
                    n_r     = r_r + PW'(1);
                    n_state = lpf_pkg::S_EXT;
                end else begin
                    n_state = lpf_pkg::S_UPD;
                end
            end
            lpf_pkg::S_UPD: begin
                if (ext_sum > r_reach) begin
                    n_reach  = ext_sum;
                    n_center = r_i;
                end
                if ((r_best < r_r) && (r_r > PW'(2))) begin
                    n_best  = r_r;
                    n_fpos  = (r_i - r_r + PW'(1)) >> 1;
                    n_epos  = PW'((ext_sum - (PW+1)'(3)) >> 1);
                    n_found = 1'b1;
                end
                if (r_i == r_last) begin
                    n_res_status = n_found ? lpf_pkg::ST_FOUND : lpf_pkg::ST_NONE;
                    n_state      = lpf_pkg::S_OUT;
                end else begin
                    n_i     = r_i + PW'(1);
                    n_state = lpf_pkg::S_SEED;
                end
            end
            lpf_pkg::S_OUT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_first_pos = 12'(r_fpos);
                    n_end_pos   = 12'(r_epos);
                    n_char_out  = r_res_char;
                    n_state     = lpf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lpf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lpf_pkg::S_IDLE;
            r_len        <= '0;
            r_new        <= 1'b1;
            r_out_valid  <= 1'b0;
            r_shift_base <= lpf_pkg::SHIFT_BASE_RST;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_new       <= n_new;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_shift_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit        <= n_hit;
        r_i          <= n_i;
        r_r          <= n_r;
        r_reach      <= n_reach;
        r_center     <= n_center;
        r_best       <= n_best;
        r_last       <= n_last;
        r_fpos       <= n_fpos;
        r_epos       <= n_epos;
        r_found      <= n_found;
        r_res_status <= n_res_status;
        r_res_char   <= n_res_char;
        r_status     <= n_status;
        r_first_pos  <= n_first_pos;
        r_end_pos    <= n_end_pos;
        r_char_out   <= n_char_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_first_pos = r_first_pos;
    assign o_end_pos   = r_end_pos;
    assign o_char_out  = r_char_out;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= NW'(MAX_LEN))
        else $error("stored length above buffer size");

    a_last_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_command == lpf_pkg::CMD_LOAD) && i_is_last)
        |=> (r_state == lpf_pkg::S_SEED) && r_new)
        else $error("last character did not start the search");

    a_radius_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpf_pkg::S_UPD) |-> (r_r <= r_i) && (r_i <= r_last))
        else $error("radius or position out of range");

    a_mirror_before: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpf_pkg::S_SEED) && (r_reach > (PW+1)'(r_i))
        |-> (rad_raddr < r_i) && (r_center < r_i))
        else $error("mirror position not yet computed");

    a_read_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_command == lpf_pkg::CMD_READ)) |=> !o_in_ready)
        else $error("new transfer taken while a read is pending");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int TEXT_DEPTH = 4096;
    localparam int SEP_DEPTH = 2 * TEXT_DEPTH + 2;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 64;

    typedef struct packed {
        logic        command;
        logic [7:0]  ch;
        logic        is_last;
        logic [11:0] rd_index;
    } t_lpf_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] first_pos;
        logic [11:0] end_pos;
        logic [7:0]  char_out;
    } t_lpf_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = lpf_pkg::CMD_LOAD;
    logic [7:0]  i_char_in = 8'd0;
    logic        i_is_last = 1'b0;
    logic [11:0] i_read_index = 12'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [11:0] o_first_pos;
    logic [11:0] o_end_pos;
    logic [7:0]  o_char_out;

    longest_palindrome_finder #(
        .MAX_LEN(TEXT_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_command(i_command),
        .i_char_in(i_char_in),
        .i_is_last(i_is_last),
        .i_read_index(i_read_index),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_first_pos(o_first_pos),
        .o_end_pos(o_end_pos),
        .o_char_out(o_char_out)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predictor state
    logic [7:0]  text_mem [TEXT_DEPTH];
    int          radius_mem [SEP_DEPTH];
    int          text_len = 0;
    bit          fresh_string = 1'b1;
    logic [7:0]  shift_base_m = lpf_pkg::SHIFT_BASE_RST;

    t_lpf_item   pending_items [$];
    t_lpf_result awaited_results [$];
    t_lpf_item   held_item;

    int  send_idle_pct = 0;
    int  sink_idle_pct = 0;
    bit  quiet = 1'b0;
    int  send_gap = 0;
    int  sink_gap = 0;
    int  errors = 0;
    int  n_queued = 0;
    int  n_accepted = 0;
    int  n_found = 0;
    int  n_none = 0;
    int  n_reads = 0;
    int  n_settings = 1;
    int  cycle_count = 0;

    function automatic bit sep_match(int lo, int hi, int last_pos);
        if (lo < 1 || hi > last_pos)
            return 1'b0;
        if (lo % 2 == 1)
            return 1'b1;
        return text_mem[((lo - 2) / 2) % TEXT_DEPTH] == text_mem[((hi - 2) / 2) % TEXT_DEPTH];
    endfunction

    function automatic t_lpf_result find_longest_palindrome();
        int last_pos, best, reach, center, first, stop, r, mirror, lim, m, i;
        bit found;
        t_lpf_result res;
        last_pos = 2 * text_len + 1;
        best = 0;
        reach = 0;
        center = 0;
        first = 0;
        stop = 0;
        found = 1'b0;
        res = '0;
        for (i = 1; i <= last_pos && i < SEP_DEPTH; i++) begin
            r = 1;
            if (reach > i) begin
                mirror = 2 * center - i;
                lim = reach - i;
                m = (mirror >= 0 && mirror < SEP_DEPTH) ? radius_mem[mirror] : 1;
                r = (m < lim) ? m : lim;
            end
            while (r <= i && sep_match(i - r, i + r, last_pos))
                r++;
            radius_mem[i] = r;
            if (r + i > reach) begin
                reach = r + i;
                center = i;
            end
            if (best < r && r > 2) begin
                best = r;
                first = (i - best + 1) / 2;
                stop = (i + best - 3) / 2;
                found = 1'b1;
            end
        end
        res.status = found ? lpf_pkg::ST_FOUND : lpf_pkg::ST_NONE;
        if (found) begin
            res.first_pos = 12'(first);
            res.end_pos = 12'(stop);
        end
        return res;
    endfunction

    function automatic t_lpf_result compute_response(t_lpf_item it);
        t_lpf_result res;
        logic [7:0] c;
        res = '0;
        if (it.command == lpf_pkg::CMD_READ) begin
            res.status = lpf_pkg::ST_RDATA;
            if (int'(it.rd_index) < text_len) begin
                c = text_mem[it.rd_index];
                if (c >= shift_base_m)
                    res.char_out = c - shift_base_m + lpf_pkg::CHAR_A;
                else
                    res.char_out = lpf_pkg::CHAR_Z - (shift_base_m - c - 8'd1);
            end
            return res;
        end
        if (fresh_string) begin
            text_len = 0;
            fresh_string = 1'b0;
        end
        if (text_len < TEXT_DEPTH) begin
            text_mem[text_len] = it.ch;
            text_len++;
        end
        if (it.is_last) begin
            fresh_string = 1'b1;
            return find_longest_palindrome();
        end
        res.status = lpf_pkg::ST_LOADED;
        return res;
    endfunction

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                awaited_results.push_back(compute_response(held_item));
                n_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (!quiet && send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
                    send_gap = $urandom_range(0, 18);
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    held_item = pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    i_command <= held_item.command;
                    i_char_in <= held_item.ch;
                    i_is_last <= held_item.is_last;
                    i_read_index <= held_item.rd_index;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_lpf_result exp_res;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with nothing expected: status %0d", o_status);
                    errors++;
                end else begin
                    exp_res = awaited_results.pop_front();
                    case (exp_res.status)
                        lpf_pkg::ST_FOUND: n_found++;
                        lpf_pkg::ST_NONE:  n_none++;
                        lpf_pkg::ST_RDATA: n_reads++;
                        default: ;
                    endcase
                    if (o_status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d", exp_res.status, o_status);
                        errors++;
                    end
                    if (o_first_pos !== exp_res.first_pos) begin
                        $error("first_pos: expected %0d, actual %0d",
                               exp_res.first_pos, o_first_pos);
                        errors++;
                    end
                    if (o_end_pos !== exp_res.end_pos) begin
                        $error("end_pos: expected %0d, actual %0d", exp_res.end_pos, o_end_pos);
                        errors++;
                    end
                    if (o_char_out !== exp_res.char_out) begin
                        $error("char_out: expected %0d, actual %0d",
                               exp_res.char_out, o_char_out);
                        errors++;
                    end
                end
            end
            if (quiet) begin
                i_out_ready <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap--;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < sink_idle_pct) begin
                sink_gap = $urandom_range(0, 18);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_load(logic [7:0] ch, logic is_last);
        t_lpf_item it;
        it.command = lpf_pkg::CMD_LOAD;
        it.ch = ch;
        it.is_last = is_last;
        it.rd_index = 12'($urandom_range(0, 4095));
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic queue_read(logic [11:0] idx);
        t_lpf_item it;
        it.command = lpf_pkg::CMD_READ;
        it.ch = 8'($urandom_range(0, 255));
        it.is_last = 1'($urandom_range(0, 1));
        it.rd_index = idx;
        pending_items.push_back(it);
        n_queued++;
    endtask

    task automatic queue_random_string();
        int len, mode, nsym, plen, pstart, pick;
        logic [7:0] syms [4];
        logic [7:0] sbuf [];
        pick = $urandom_range(0, 99);
        if (pick < 70)
            len = $urandom_range(1, 16);
        else if (pick < 95)
            len = $urandom_range(17, 64);
        else
            len = $urandom_range(65, 400);
        mode = $urandom_range(0, 3);
        nsym = $urandom_range(1, 4);
        foreach (syms[s])
            syms[s] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0: syms[0] = 8'h23;
                1: syms[0] = 8'h21;
                default: syms[0] = 8'h00;
            endcase
        end
        sbuf = new[len];
        foreach (sbuf[p])
            sbuf[p] = (mode == 0) ? 8'($urandom_range(0, 255))
                                  : syms[$urandom_range(0, nsym - 1)];
        // plant a palindrome somewhere in the string
        if (len >= 2 && $urandom_range(0, 1) == 1) begin
            plen = $urandom_range(2, len);
            pstart = $urandom_range(0, len - plen);
            for (int q = 0; q < plen / 2; q++)
                sbuf[pstart + plen - 1 - q] = sbuf[pstart + q];
        end
        for (int q = 0; q < len; q++) begin
            if ($urandom_range(0, 99) < 8)
                queue_read(12'($urandom_range(0, q + 1)));
            queue_load(sbuf[q], q == len - 1);
        end
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 3) == 0)
                queue_read(12'($urandom_range(0, 4095)));
            else
                queue_read(12'($urandom_range(0, len)));
        end
    endtask

    // full-buffer palindrome followed by characters that get dropped
    task automatic queue_long_string();
        logic [7:0] c;
        logic [7:0] sbuf [TEXT_DEPTH];
        for (int q = 0; q < TEXT_DEPTH / 2; q++) begin
            c = 8'($urandom_range(0, 255));
            sbuf[q] = c;
            sbuf[TEXT_DEPTH - 1 - q] = c;
        end
        foreach (sbuf[p])
            queue_load(sbuf[p], 1'b0);
        repeat (3)
            queue_load(8'($urandom_range(0, 255)), 1'b0);
        queue_load(8'($urandom_range(0, 255)), 1'b1);
        queue_read(12'd4095);
        queue_read(12'd4094);
        queue_read(12'd2048);
        queue_read(12'd0);
        repeat (8)
            queue_read(12'($urandom_range(0, 4095)));
    endtask

    task automatic wait_idle();
        do
            @(posedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || awaited_results.size() != 0);
    endtask

    task automatic set_shift_base(logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        shift_base_m = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic run_phase(logic [7:0] base, int send_pct, int sink_pct, int count);
        int start;
        wait_idle();
        set_shift_base(base);
        send_idle_pct = send_pct;
        sink_idle_pct = sink_pct;
        start = n_queued;
        while (n_queued - start < count)
            queue_random_string();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset shift base
        send_idle_pct = 10;
        sink_idle_pct = 10;
        queue_read(12'd0);
        queue_read(12'd4095);
        queue_load("a", 1'b1);
        queue_load("a", 1'b0);
        queue_load("a", 1'b1);
        queue_load(8'h00, 1'b0);
        queue_load("#", 1'b0);
        queue_load("!", 1'b0);
        queue_load("#", 1'b0);
        queue_load(8'h00, 1'b1);
        queue_load("x", 1'b0);
        queue_load("y", 1'b1);
        queue_read(12'd0);
        queue_read(12'd1);
        queue_read(12'd2);
        queue_load(8'h60, 1'b0);
        queue_load(8'hff, 1'b0);
        queue_load("b", 1'b1);
        queue_read(12'd0);
        queue_read(12'd1);
        queue_read(12'd2);
        queue_load("q", 1'b0);
        queue_load("r", 1'b0);
        queue_read(12'd1);
        queue_load("r", 1'b0);
        queue_load("q", 1'b1);
        queue_read(12'd3);

        run_phase(8'd0, 0, 0, 200);
        run_phase(8'd255, 20, 5, 200);
        run_phase(8'($urandom_range(0, 255)), 5, 30, 200);
        run_phase(lpf_pkg::SHIFT_BASE_RST, 40, 40, 200);
        run_phase(8'($urandom_range(0, 255)), 10, 0, 200);
        run_phase(8'($urandom_range(0, 255)), 0, 15, 150);

        wait_idle();
        set_shift_base(8'($urandom_range(0, 255)));
        send_idle_pct = 15;
        sink_idle_pct = 15;
        queue_long_string();

        // last stretch runs with no idling
        wait_idle();
        set_shift_base(8'($urandom_range(0, 255)));
        quiet = 1'b1;
        while (n_queued < 1320 + TEXT_DEPTH)
            queue_random_string();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d transfers in over %0d shift_base settings, one full-buffer string",
                 n_accepted, n_settings);
        $display("%0d searches with a palindrome, %0d without, %0d reads, %0d cycles",
                 n_found, n_none, n_reads, cycle_count);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
